### hw/rtl/stok_pkg.sv
// stok_pkg: token codes, lexer mode codes and the keyword match function for the
// source tokenizer. Depends on nothing; used by stok_lex and source_tokenizer_top.
package stok_pkg;

   localparam int KeywordMaxDefault = 8;
   localparam int PositionBitsDefault = 16;

   localparam logic [1:0] REC_VALUE = 2'd0;
   localparam logic [1:0] REC_TOKEN = 2'd1;
   localparam logic [1:0] REC_ABANDON = 2'd2;

   localparam logic [5:0] TK_COLON = 6'd9;
   localparam logic [5:0] TK_ADD = 6'd10;
   localparam logic [5:0] TK_ADD_ADD = 6'd11;
   localparam logic [5:0] TK_ADD_EQ = 6'd12;
   localparam logic [5:0] TK_SUB = 6'd13;
   localparam logic [5:0] TK_SUB_SUB = 6'd14;
   localparam logic [5:0] TK_SUB_EQ = 6'd15;
   localparam logic [5:0] TK_RARROW = 6'd16;
   localparam logic [5:0] TK_MUL = 6'd17;
   localparam logic [5:0] TK_MUL_EQ = 6'd18;
   localparam logic [5:0] TK_DIV = 6'd19;
   localparam logic [5:0] TK_DIV_EQ = 6'd20;
   localparam logic [5:0] TK_MOD = 6'd21;
   localparam logic [5:0] TK_ASSIGN = 6'd22;
   localparam logic [5:0] TK_EQ_EQ = 6'd23;
   localparam logic [5:0] TK_NOT = 6'd24;
   localparam logic [5:0] TK_NOT_EQ = 6'd25;
   localparam logic [5:0] TK_LT = 6'd26;
   localparam logic [5:0] TK_LT_EQ = 6'd27;
   localparam logic [5:0] TK_GT = 6'd28;
   localparam logic [5:0] TK_GT_EQ = 6'd29;
   localparam logic [5:0] TK_AMP = 6'd30;
   localparam logic [5:0] TK_BAR = 6'd31;
   localparam logic [5:0] TK_TILDE = 6'd32;
   localparam logic [5:0] TK_STR_LIT = 6'd33;
   localparam logic [5:0] TK_INT_LIT = 6'd34;
   localparam logic [5:0] TK_NAME = 6'd35;
   localparam logic [5:0] TK_BAD = 6'd36;
   localparam logic [5:0] TK_FINISH = 6'd37;
   localparam logic [5:0] TK_LPAR = 6'd0;
   localparam logic [5:0] TK_RPAR = 6'd1;
   localparam logic [5:0] TK_LCURLY = 6'd2;
   localparam logic [5:0] TK_RCURLY = 6'd3;
   localparam logic [5:0] TK_LSQ = 6'd4;
   localparam logic [5:0] TK_RSQ = 6'd5;
   localparam logic [5:0] TK_SEMI = 6'd6;
   localparam logic [5:0] TK_COMMA = 6'd7;
   localparam logic [5:0] TK_DOT = 6'd8;

   localparam logic [4:0] M_IDLE = 5'd0;
   localparam logic [4:0] M_WORD = 5'd1;
   localparam logic [4:0] M_NUM_FIRST = 5'd2;
   localparam logic [4:0] M_NUM_DEC = 5'd3;
   localparam logic [4:0] M_NUM_HEX = 5'd4;
   localparam logic [4:0] M_STR = 5'd5;
   localparam logic [4:0] M_STR_ESC = 5'd6;
   localparam logic [4:0] M_LINE_CMT = 5'd7;
   localparam logic [4:0] M_BLOCK = 5'd8;
   localparam logic [4:0] M_BLOCK_STAR = 5'd9;
   localparam logic [4:0] M_P_COLON = 5'd10;
   localparam logic [4:0] M_P_PLUS = 5'd11;
   localparam logic [4:0] M_P_MINUS = 5'd12;
   localparam logic [4:0] M_P_STAR = 5'd13;
   localparam logic [4:0] M_P_SLASH = 5'd14;
   localparam logic [4:0] M_P_EQ = 5'd15;
   localparam logic [4:0] M_P_BANG = 5'd16;
   localparam logic [4:0] M_P_LT = 5'd17;
   localparam logic [4:0] M_P_GT = 5'd18;
   localparam logic [4:0] M_P_AMP = 5'd19;
   localparam logic [4:0] M_P_PIPE = 5'd20;

   typedef struct packed {
      logic [1:0] record_kind;
      logic [5:0] token_kind;
      logic [7:0] value_byte;
   } rec_type;

   // Keyword lookup on the first eight buffered bytes; len is the word length.
   function automatic logic [5:0] keyword_kind(input logic [63:0] w, input logic [3:0] len);
      logic [5:0] k;
      k = TK_NAME;
      case (len)
         4'd2: begin
            if (w[15:0] == {"n", "f"}) k = 6'd38;
            if (w[15:0] == {"f", "i"}) k = 6'd40;
         end
         4'd3: begin
            if (w[23:0] == {"r", "o", "f"}) k = 6'd43;
            if (w[23:0] == {"t", "e", "l"}) k = 6'd46;
            if (w[23:0] == {"t", "n", "i"}) k = 6'd49;
            if (w[23:0] == {"r", "t", "s"}) k = 6'd52;
         end
         4'd4: begin
            if (w[31:0] == {"e", "s", "l", "e"}) k = 6'd41;
            if (w[31:0] == {"r", "a", "h", "c"}) k = 6'd50;
            if (w[31:0] == {"l", "o", "o", "b"}) k = 6'd51;
            if (w[31:0] == {"d", "i", "o", "v"}) k = 6'd53;
            if (w[31:0] == {"e", "u", "r", "t"}) k = 6'd54;
         end
         4'd5: begin
            if (w[39:0] == {"e", "l", "i", "h", "w"}) k = 6'd42;
            if (w[39:0] == {"k", "a", "e", "r", "b"}) k = 6'd44;
            if (w[39:0] == {"e", "s", "l", "a", "f"}) k = 6'd55;
         end
         4'd6: begin
            if (w[47:0] == {"n", "r", "u", "t", "e", "r"}) k = 6'd39;
            if (w[47:0] == {"n", "r", "e", "t", "x", "e"}) k = 6'd47;
            if (w[47:0] == {"f", "o", "e", "z", "i", "s"}) k = 6'd48;
         end
         4'd8: begin
            if (w == {"e", "u", "n", "i", "t", "n", "o", "c"}) k = 6'd45;
         end
         default: k = TK_NAME;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/stok_if.sv
// stok_if: valid/ready channels for the tokenizer's source and record words.
// Depends on nothing.
interface stok_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic [7:0] char_code;
   modport source (output valid, kind, char_code, input ready);
   modport sink (input valid, kind, char_code, output ready);
endinterface

interface stok_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] record_kind;
   logic [5:0] token_kind;
   logic [7:0] value_byte;
   logic [15:0] line_number;
   logic [15:0] column_number;
   logic last_of_run;
   modport source (output valid, record_kind, token_kind, value_byte, line_number,
                   column_number, last_of_run, input ready);
   modport sink (input valid, record_kind, token_kind, value_byte, line_number,
                 column_number, last_of_run, output ready);
endinterface

### hw/rtl/stok_lex.sv
// stok_lex: next-state and record logic for one source word.
// Depends on stok_pkg.
module stok_lex #(
   parameter int KEYWORD_MAX = stok_pkg::KeywordMaxDefault,
   parameter int POSITION_BITS = stok_pkg::PositionBitsDefault,
   localparam int LenBits = $clog2(KEYWORD_MAX + 2)
) (
   input  logic                          is_end,
   input  logic [7:0]                    ch,
   input  logic [4:0]                    mode,
   input  logic [POSITION_BITS-1:0]      line_cur,
   input  logic [POSITION_BITS-1:0]      col_cur,
   input  logic [KEYWORD_MAX*8-1:0]      word,
   input  logic [LenBits-1:0]            wlen,
   output logic [4:0]                    mode_nx,
   output logic [POSITION_BITS-1:0]      line_nx,
   output logic [POSITION_BITS-1:0]      col_nx,
   output logic [LenBits-1:0]            wlen_nx,
   output logic                          wput,
   output logic [1:0]                    rec_cnt,
   output stok_pkg::rec_type [2:0]       recs,
   output logic [2:0]                    rec_late
);
   localparam logic [POSITION_BITS-1:0] PosMax = '1;
   localparam logic [LenBits-1:0] KwMax = LenBits'(KEYWORD_MAX);

   logic [POSITION_BITS-1:0] line_t, col_t;
   logic is_dig, is_alp, is_hx, is_wd;
   logic [5:0] wkind, close_kind;
   logic closing, fresh;
   // fresh-char outcome
   logic [4:0] f_mode;
   logic [1:0] f_n;
   stok_pkg::rec_type f_r0, f_r1;
   logic f_word;

   always_comb begin
      if (ch == 8'h0a) begin
         line_t = (line_cur < PosMax) ? line_cur + 1'b1 : line_cur;
         col_t = POSITION_BITS'(1);
      end else begin
         line_t = line_cur;
         col_t = (col_cur < PosMax) ? col_cur + 1'b1 : col_cur;
      end
   end

   assign is_dig = ch >= "0" && ch <= "9";
   assign is_alp = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   assign is_hx = is_dig || (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
   assign is_wd = is_alp || is_dig || ch == "_";
   assign wkind = (wlen > KwMax || wlen > LenBits'(8)) ? stok_pkg::TK_NAME :
                  stok_pkg::keyword_kind(word[63:0], 4'(wlen));

   function automatic stok_pkg::rec_type tk(input logic [5:0] k);
      return '{record_kind: stok_pkg::REC_TOKEN, token_kind: k, value_byte: 8'd0};
   endfunction
   function automatic stok_pkg::rec_type vb(input logic [7:0] b);
      return '{record_kind: stok_pkg::REC_VALUE, token_kind: 6'd0, value_byte: b};
   endfunction

   always_comb begin
      f_mode = stok_pkg::M_IDLE;
      f_n = 2'd0;
      f_r0 = vb(ch);
      f_r1 = tk(stok_pkg::TK_BAD);
      f_word = 1'b0;
      case (ch)
         " ", 8'h09, 8'h0d, 8'h0a: f_n = 2'd0;
         "(": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_LPAR); end
         ")": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_RPAR); end
         "{": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_LCURLY); end
         "}": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_RCURLY); end
         "[": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_LSQ); end
         "]": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_RSQ); end
         ";": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_SEMI); end
         ",": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_COMMA); end
         ".": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_DOT); end
         "%": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_MOD); end
         "~": begin f_n = 2'd1; f_r0 = tk(stok_pkg::TK_TILDE); end
         ":": f_mode = stok_pkg::M_P_COLON;
         "+": f_mode = stok_pkg::M_P_PLUS;
         "-": f_mode = stok_pkg::M_P_MINUS;
         "*": f_mode = stok_pkg::M_P_STAR;
         "/": f_mode = stok_pkg::M_P_SLASH;
         "=": f_mode = stok_pkg::M_P_EQ;
         "!": f_mode = stok_pkg::M_P_BANG;
         "<": f_mode = stok_pkg::M_P_LT;
         ">": f_mode = stok_pkg::M_P_GT;
         "&": f_mode = stok_pkg::M_P_AMP;
         "|": f_mode = stok_pkg::M_P_PIPE;
         "\"": f_mode = stok_pkg::M_STR;
         default: begin
            f_n = 2'd1;
            if (is_dig) f_mode = stok_pkg::M_NUM_FIRST;
            else if (is_alp || ch == "_") begin
               f_mode = stok_pkg::M_WORD;
               f_word = 1'b1;
            end else f_n = 2'd2;
         end
      endcase
   end

   always_comb begin
      mode_nx = mode;
      line_nx = line_t;
      col_nx = col_t;
      wlen_nx = wlen;
      wput = 1'b0;
      rec_cnt = 2'd0;
      recs = '{default: vb(ch)};
      rec_late = 3'b111;
      closing = 1'b0;
      close_kind = stok_pkg::TK_INT_LIT;
      fresh = 1'b0;
      if (is_end) begin
         line_nx = POSITION_BITS'(1);
         col_nx = POSITION_BITS'(1);
         wlen_nx = '0;
         mode_nx = stok_pkg::M_IDLE;
         rec_late = 3'b000;
         rec_cnt = 2'd2;
         recs[1] = tk(stok_pkg::TK_FINISH);
         case (mode)
            stok_pkg::M_WORD: recs[0] = tk(wkind);
            stok_pkg::M_NUM_FIRST, stok_pkg::M_NUM_DEC, stok_pkg::M_NUM_HEX:
               recs[0] = tk(stok_pkg::TK_INT_LIT);
            stok_pkg::M_STR, stok_pkg::M_STR_ESC:
               recs[0] = '{record_kind: stok_pkg::REC_ABANDON, token_kind: 6'd0,
                           value_byte: 8'd0};
            stok_pkg::M_P_COLON: recs[0] = tk(stok_pkg::TK_COLON);
            stok_pkg::M_P_PLUS: recs[0] = tk(stok_pkg::TK_ADD);
            stok_pkg::M_P_MINUS: recs[0] = tk(stok_pkg::TK_SUB);
            stok_pkg::M_P_STAR: recs[0] = tk(stok_pkg::TK_MUL);
            stok_pkg::M_P_SLASH: recs[0] = tk(stok_pkg::TK_DIV);
            stok_pkg::M_P_EQ: recs[0] = tk(stok_pkg::TK_ASSIGN);
            stok_pkg::M_P_BANG: recs[0] = tk(stok_pkg::TK_NOT);
            stok_pkg::M_P_LT: recs[0] = tk(stok_pkg::TK_LT);
            stok_pkg::M_P_GT: recs[0] = tk(stok_pkg::TK_GT);
            stok_pkg::M_P_AMP: recs[0] = tk(stok_pkg::TK_AMP);
            stok_pkg::M_P_PIPE: recs[0] = tk(stok_pkg::TK_BAR);
            default: begin
               rec_cnt = 2'd1;
               recs[0] = tk(stok_pkg::TK_FINISH);
            end
         endcase
      end else begin
         case (mode)
            stok_pkg::M_IDLE: fresh = 1'b1;
            stok_pkg::M_WORD:
               if (is_wd) begin
                  wput = 1'b1;
                  rec_cnt = 2'd1;
               end else begin
                  closing = 1'b1;
                  close_kind = wkind;
               end
            stok_pkg::M_NUM_FIRST:
               if (is_dig) begin
                  rec_cnt = 2'd1;
                  mode_nx = stok_pkg::M_NUM_DEC;
               end else if (ch == "x" || ch == "X") begin
                  rec_cnt = 2'd1;
                  mode_nx = stok_pkg::M_NUM_HEX;
               end else closing = 1'b1;
            stok_pkg::M_NUM_DEC:
               if (is_dig) rec_cnt = 2'd1;
               else closing = 1'b1;
            stok_pkg::M_NUM_HEX:
               if (is_hx) rec_cnt = 2'd1;
               else closing = 1'b1;
            stok_pkg::M_STR:
               if (ch == "\"") begin
                  rec_cnt = 2'd1;
                  recs[0] = tk(stok_pkg::TK_STR_LIT);
                  mode_nx = stok_pkg::M_IDLE;
               end else if (ch == "\\") mode_nx = stok_pkg::M_STR_ESC;
               else rec_cnt = 2'd1;
            stok_pkg::M_STR_ESC: begin
               rec_cnt = 2'd1;
               mode_nx = stok_pkg::M_STR;
               case (ch)
                  "n": recs[0] = vb(8'h0a);
                  "t": recs[0] = vb(8'h09);
                  "0": recs[0] = vb(8'h00);
                  "\"": recs[0] = vb(8'h22);
                  default: recs[0] = vb(8'h5c);
               endcase
            end
            stok_pkg::M_LINE_CMT: if (ch == 8'h0a) mode_nx = stok_pkg::M_IDLE;
            stok_pkg::M_BLOCK: if (ch == "*") mode_nx = stok_pkg::M_BLOCK_STAR;
            stok_pkg::M_BLOCK_STAR:
               if (ch == "/") mode_nx = stok_pkg::M_IDLE;
               else if (ch != "*") mode_nx = stok_pkg::M_BLOCK;
            stok_pkg::M_P_COLON:
               if (ch == ":") mode_nx = stok_pkg::M_IDLE;
               else begin closing = 1'b1; close_kind = stok_pkg::TK_COLON; end
            stok_pkg::M_P_PIPE:
               if (ch == "|") mode_nx = stok_pkg::M_IDLE;
               else begin closing = 1'b1; close_kind = stok_pkg::TK_BAR; end
            stok_pkg::M_P_PLUS: begin
               mode_nx = stok_pkg::M_IDLE;
               rec_cnt = 2'd1;
               if (ch == "+") recs[0] = tk(stok_pkg::TK_ADD_ADD);
               else if (ch == "=") recs[0] = tk(stok_pkg::TK_ADD_EQ);
               else begin rec_cnt = 2'd0; closing = 1'b1; close_kind = stok_pkg::TK_ADD; end
            end
            stok_pkg::M_P_MINUS: begin
               mode_nx = stok_pkg::M_IDLE;
               rec_cnt = 2'd1;
               if (ch == "-") recs[0] = tk(stok_pkg::TK_SUB_SUB);
               else if (ch == "=") recs[0] = tk(stok_pkg::TK_SUB_EQ);
               else if (ch == ">") recs[0] = tk(stok_pkg::TK_RARROW);
               else begin rec_cnt = 2'd0; closing = 1'b1; close_kind = stok_pkg::TK_SUB; end
            end
            stok_pkg::M_P_SLASH:
               if (ch == "/") mode_nx = stok_pkg::M_LINE_CMT;
               else if (ch == "*") mode_nx = stok_pkg::M_BLOCK;
               else if (ch == "=") begin
                  mode_nx = stok_pkg::M_IDLE;
                  rec_cnt = 2'd1;
                  recs[0] = tk(stok_pkg::TK_DIV_EQ);
               end else begin closing = 1'b1; close_kind = stok_pkg::TK_DIV; end
            stok_pkg::M_P_STAR, stok_pkg::M_P_EQ, stok_pkg::M_P_BANG, stok_pkg::M_P_LT,
            stok_pkg::M_P_GT, stok_pkg::M_P_AMP: begin
               // base kind and its extended kind sit one code apart; for amp that is the bar code
               case (mode)
                  stok_pkg::M_P_STAR: close_kind = stok_pkg::TK_MUL;
                  stok_pkg::M_P_EQ: close_kind = stok_pkg::TK_ASSIGN;
                  stok_pkg::M_P_BANG: close_kind = stok_pkg::TK_NOT;
                  stok_pkg::M_P_LT: close_kind = stok_pkg::TK_LT;
                  stok_pkg::M_P_GT: close_kind = stok_pkg::TK_GT;
                  default: close_kind = stok_pkg::TK_AMP;
               endcase
               if ((mode == stok_pkg::M_P_AMP) ? ch == "&" : ch == "=") begin
                  mode_nx = stok_pkg::M_IDLE;
                  rec_cnt = 2'd1;
                  recs[0] = tk(close_kind + 6'd1);
               end else closing = 1'b1;
            end
            default: fresh = 1'b1;
         endcase
         if (fresh || closing) begin
            mode_nx = f_mode;
            if (f_word) begin
               wput = 1'b1;
               wlen_nx = '0;
            end
         end
         if (fresh) begin
            rec_cnt = f_n;
            recs[0] = f_r0;
            recs[1] = f_r1;
         end
         if (closing) begin
            // closing token carries the position before this byte
            rec_cnt = f_n + 2'd1;
            recs[0] = tk(close_kind);
            recs[1] = f_r0;
            recs[2] = f_r1;
            rec_late = 3'b110;
         end
         if (wput) begin
            if (f_word && (fresh || closing)) wlen_nx = LenBits'(1);
            else if (wlen <= KwMax) wlen_nx = wlen + 1'b1;
         end
      end
   end
endmodule

### hw/rtl/source_tokenizer_top.sv
// Source tokenizer: one byte a cycle in unless stalled, up to three result words out.
// A source word's first result word is registered, shown the cycle after it is taken.
// Throughput: one source word per cycle while each yields at most one result and the
// sink is ready; a word with more results holds the input until the queue drains.
// Reset (synchronous, active high): mode idle, line and column 1, queue empty.
// Depends on stok_pkg, stok_if and stok_lex.
module source_tokenizer_top #(
   parameter int KEYWORD_MAX = stok_pkg::KeywordMaxDefault,
   parameter int POSITION_BITS = stok_pkg::PositionBitsDefault
) (
   input logic clock,
   input logic reset,
   stok_req_if.sink req,
   stok_rsp_if.source rsp
);
   localparam int LenBits = $clog2(KEYWORD_MAX + 2);
   localparam int IdxBits = $clog2(KEYWORD_MAX);

   logic [4:0] mode_ff, mode_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in;
   logic [7:0] wbuf_ff [KEYWORD_MAX];
   logic [KEYWORD_MAX*8-1:0] word;
   logic [LenBits-1:0] wlen_ff, wlen_in;
   logic wput;
   logic [1:0] rec_cnt;
   stok_pkg::rec_type [2:0] recs;
   logic [2:0] rec_late;
   logic [LenBits-1:0] widx;

   // output queue: up to three words of one source word, each with position
   stok_pkg::rec_type q_rec_ff [3];
   logic [POSITION_BITS-1:0] q_line_ff [3], q_col_ff [3];
   logic [1:0] q_cnt_ff, q_head_ff;
   logic accept, pop;

   always_comb begin
      for (int i = 0; i < KEYWORD_MAX; i++) word[i*8 +: 8] = wbuf_ff[i];
   end

   stok_lex #(.KEYWORD_MAX(KEYWORD_MAX), .POSITION_BITS(POSITION_BITS)) u_lex (
      .is_end(req.kind), .ch(req.char_code), .mode(mode_ff), .line_cur(line_ff),
      .col_cur(col_ff), .word(word), .wlen(wlen_ff), .mode_nx(mode_in),
      .line_nx(line_in), .col_nx(col_in), .wlen_nx(wlen_in), .wput(wput),
      .rec_cnt(rec_cnt), .recs(recs), .rec_late(rec_late));

   // accept when the queue is empty or its last word leaves this cycle
   assign pop = rsp.valid && rsp.ready;
   assign accept = req.valid && req.ready;
   assign req.ready = (q_cnt_ff == 2'd0) || (q_cnt_ff == 2'd1 && rsp.ready);

   assign rsp.valid = q_cnt_ff != 2'd0;
   assign rsp.record_kind = q_rec_ff[q_head_ff].record_kind;
   assign rsp.token_kind = q_rec_ff[q_head_ff].token_kind;
   assign rsp.value_byte = q_rec_ff[q_head_ff].value_byte;
   assign rsp.line_number = 16'(q_line_ff[q_head_ff]);
   assign rsp.column_number = 16'(q_col_ff[q_head_ff]);
   assign rsp.last_of_run = q_cnt_ff == 2'd1;

   // the word buffer slot is the length before the bump (zero on a new word)
   assign widx = (wlen_in == LenBits'(1)) ? '0 : wlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stok_pkg::M_IDLE;
         line_ff <= POSITION_BITS'(1);
         col_ff <= POSITION_BITS'(1);
         wlen_ff <= '0;
         q_cnt_ff <= 2'd0;
         q_head_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff <= col_in;
         wlen_ff <= wlen_in;
         q_cnt_ff <= rec_cnt;
         q_head_ff <= 2'd0;
      end else if (pop) begin
         q_cnt_ff <= q_cnt_ff - 2'd1;
         q_head_ff <= q_head_ff + 2'd1;
      end
   end

   // payload: word buffer and queued words
   always_ff @(posedge clock) begin
      if (accept && !req.kind && wput && widx < LenBits'(KEYWORD_MAX))
         wbuf_ff[widx[IdxBits-1:0]] <= req.char_code;
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            q_rec_ff[i] <= recs[i];
            q_line_ff[i] <= rec_late[i] ? line_in : line_ff;
            q_col_ff[i] <= rec_late[i] ? col_in : col_ff;
         end
      end
   end
endmodule

### hw/rtl/stok_check.sv
// stok_check: port-level assertions for source_tokenizer_top, bound to it.
// Depends on stok_pkg only through the bound top level's ports.
module stok_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_record_kind,
   input logic [15:0] rsp_column_number,
   input logic rsp_last_of_run
);
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_record_kind != 2'd3) else $error("bad record kind");
   a_no_take_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> !req_ready) else $error("ready mid run");
   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_column_number != 16'd0) else $error("column zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("valid dropped");
endmodule

bind source_tokenizer_top stok_check u_stok_check (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_record_kind(rsp.record_kind),
   .rsp_column_number(rsp.column_number), .rsp_last_of_run(rsp.last_of_run));
